@@ rtl/ccw_pkg.sv @@
// shared types, constants and helpers for the cubic congestion window block
// used by ccw_muldiv and cubic_congestion_window; depends on nothing else
package ccw_pkg;

  // fixed point format of window, threshold and curve values
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned BYTE_W    = 40;
  localparam int unsigned WIN_W     = BYTE_W + FRAC_BITS;
  localparam int unsigned TIME_W    = 56;
  localparam int unsigned K_W       = 40;
  localparam int unsigned CNT_W     = 32;
  localparam int unsigned REL_W     = 10;

  localparam logic [63:0] ONE_Q      = 64'(1) << FRAC_BITS;
  localparam logic [WIN_W-1:0] WIN_MAX = {{BYTE_W{1'b1}}, {FRAC_BITS{1'b0}}};
  localparam logic [15:0] SEG_RESET  = 16'd1500;
  localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(15000) << FRAC_BITS;
  localparam logic [5:0] TSHIFT_RESET = 6'd30;

  // stream payload widths
  localparam int unsigned IN_DATA_W  = 112;
  localparam int unsigned OUT_DATA_W = 192;

  // event kinds carried in tuser
  typedef enum logic [1:0] {
    OP_ACK   = 2'd0,
    OP_NACK  = 2'd1,
    OP_START = 2'd2
  } op_e;

  // register indexes on the configuration port
  typedef enum logic [1:0] {
    REG_SEGMENT  = 2'd0,
    REG_TSHIFT   = 2'd1,
    REG_FRIENDLY = 2'd2,
    REG_FASTCONV = 2'd3
  } reg_idx_e;

  // request to and response from the shared multiply-divide unit
  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] d;
  } md_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] q;
    logic [63:0] rem;
  } md_rsp_t;

  // saturate a 64 bit value to 32 bits
  function automatic logic [31:0] sat32(input logic [63:0] v);
    sat32 = (|v[63:32]) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  // 64 bit add that saturates at all ones
  function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    sat_add64 = s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
  endfunction

endpackage

@@ rtl/ccw_muldiv.sv @@
// shared unit computing floor(a*b/d), saturated to 64 bits, plus the remainder
// uses ccw_pkg for the request and response structs
module ccw_muldiv (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ccw_pkg::md_req_t req_i,
  output ccw_pkg::md_rsp_t rsp_o
);
  import ccw_pkg::*;

  typedef enum logic [4:0] {
    MD_IDLE = 5'b00001,
    MD_MUL  = 5'b00010,
    MD_CHK  = 5'b00100,
    MD_DIV  = 5'b01000,
    MD_DONE = 5'b10000
  } md_state_e;

  md_state_e    state_q, state_d;
  logic [5:0]   cnt_q, cnt_d;
  logic [63:0]  a_q, a_d, b_q, b_d, d_q, d_d;
  logic [63:0]  prod_q, prod_d;
  logic [1:0]   psh_q, psh_d;
  logic [127:0] acc_q, acc_d;
  logic [63:0]  rem_q, rem_d, quo_q, quo_d;

  // sequencer: four 32x32 partial products, then one quotient bit a cycle
  always_comb begin
    logic [31:0] a_sel, b_sel;
    logic [64:0] trial;
    logic        take;
    state_d = state_q;
    cnt_d   = cnt_q;
    a_d     = a_q;
    b_d     = b_q;
    d_d     = d_q;
    prod_d  = prod_q;
    psh_d   = psh_q;
    acc_d   = acc_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    a_sel   = cnt_q[1] ? a_q[63:32] : a_q[31:0];
    b_sel   = cnt_q[0] ? b_q[63:32] : b_q[31:0];
    trial   = {rem_q, acc_q[63]};
    take    = (trial >= {1'b0, d_q});
    unique case (state_q)
      MD_IDLE: begin
        if (req_i.start) begin
          a_d     = req_i.a;
          b_d     = req_i.b;
          d_d     = req_i.d;
          acc_d   = '0;
          cnt_d   = '0;
          state_d = MD_MUL;
        end
      end
      MD_MUL: begin
        if (cnt_q != 6'd0) begin
          acc_d = acc_q + ({64'd0, prod_q} << {psh_q, 5'd0});
        end
        if (cnt_q[2]) begin
          state_d = MD_CHK;
        end else begin
          prod_d = a_sel * b_sel;
          psh_d  = 2'({1'b0, cnt_q[1]} + {1'b0, cnt_q[0]});
        end
        cnt_d = cnt_q + 6'd1;
      end
      MD_CHK: begin
        if (d_q == 64'd0 || acc_q[127:64] >= d_q) begin
          quo_d   = '1;
          rem_d   = '0;
          state_d = MD_DONE;
        end else begin
          rem_d   = acc_q[127:64];
          cnt_d   = '0;
          state_d = MD_DIV;
        end
      end
      MD_DIV: begin
        rem_d = take ? 64'(trial - {1'b0, d_q}) : trial[63:0];
        quo_d = {quo_q[62:0], take};
        acc_d = {acc_q[127:64], acc_q[62:0], 1'b0};
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          state_d = MD_DONE;
        end
      end
      MD_DONE: begin
        state_d = MD_IDLE;
      end
      default: begin
        state_d = MD_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MD_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // operands and datapath
  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    d_q    <= d_d;
    prod_q <= prod_d;
    psh_q  <= psh_d;
    acc_q  <= acc_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
  end

  assign rsp_o.busy = (state_q != MD_IDLE);
  assign rsp_o.done = (state_q == MD_DONE);
  assign rsp_o.q    = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule

@@ rtl/cubic_congestion_window.sv @@
// top level of the cubic congestion window block: event sequencer and apb registers
// depends on ccw_pkg and ccw_muldiv
//
// One beat in, one beat out. Each event beat (ack, nack or start) is worked
// through by a small sequencer around a single shared multiply-divide unit
// (four 32x32 partial products, then one quotient bit per cycle), and the
// block takes no new beat until the result beat is registered. An ack that
// opens a new epoch below the remembered maximum also runs the 40-step cube
// root (81 calls to the unit). A result beat may wait on m_axis_tready while
// the next event is already being accepted.
module cubic_congestion_window (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // event input
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // tdata: now_time[55:0], ack_timestamp[111:56]
  input  logic [ccw_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: operation[1:0]
  input  logic [1:0]                     s_axis_tuser,
  // result output
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // tdata: window_bytes[39:0], threshold_bytes[79:40], packets_released[89:80],
  //        flight_bytes[129:90], min_rtt[185:130], zero pad above
  output logic [ccw_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [3:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import ccw_pkg::*;

  typedef enum logic [20:0] {
    ST_IDLE      = 21'h000001,
    ST_NACK_MAX  = 21'h000002,
    ST_NACK_WIN  = 21'h000004,
    ST_SS_INC    = 21'h000008,
    ST_SS_ADD    = 21'h000010,
    ST_CU_EPOCH  = 21'h000020,
    ST_ROOT_V    = 21'h000040,
    ST_ROOT_SQ   = 21'h000080,
    ST_ROOT_CB   = 21'h000100,
    ST_CU_DIFF   = 21'h000200,
    ST_CU_SCALE  = 21'h000400,
    ST_CU_SQ     = 21'h000800,
    ST_CU_CB     = 21'h001000,
    ST_CU_TGT    = 21'h002000,
    ST_CU_DELTA  = 21'h004000,
    ST_CU_RENO1  = 21'h008000,
    ST_CU_RENO2  = 21'h010000,
    ST_CU_CAP    = 21'h020000,
    ST_CU_INC    = 21'h040000,
    ST_REL       = 21'h080000,
    ST_OUT       = 21'h100000
  } state_e;

  // configuration registers
  logic [15:0] seg_q;
  logic [5:0]  tshift_q;
  logic        tfe_q, fce_q;
  logic        cfg_wr;

  // flow state
  state_e           state_q, state_d;
  logic [WIN_W-1:0] window_q, window_d, thr_q, thr_d, lmw_q, lmw_d;
  logic [WIN_W-1:0] reno_q, reno_d, origin_q, origin_d;
  logic [K_W-1:0]   koff_q, koff_d;
  logic [TIME_W-1:0] epoch_q, epoch_d, rtt_q, rtt_d, ts_q, ts_d;
  logic [CNT_W-1:0] acks_q, acks_d, incr_q, incr_d, delta_q, delta_d;
  logic [BYTE_W-1:0] flight_q, flight_d;
  logic             started_q, started_d, issued_q, issued_d;
  logic             out_valid_q, out_valid_d, neg_q, neg_d;
  logic [63:0]      tmp_q, tmp_d, v_q, v_d, dmag_q, dmag_d;
  logic [5:0]       bit_q, bit_d;
  logic [REL_W-1:0] n_q, n_d;
  logic [OUT_DATA_W-1:0] out_data_q, out_data_d;

  md_req_t md_req;
  md_rsp_t md_rsp;

  ccw_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (md_req),
    .rsp_o  (md_rsp)
  );

  // apb access
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    unique case (reg_idx_e'(paddr[3:2]))
      REG_SEGMENT:  prdata = {16'd0, seg_q};
      REG_TSHIFT:   prdata = {26'd0, tshift_q};
      REG_FRIENDLY: prdata = {31'd0, tfe_q};
      REG_FASTCONV: prdata = {31'd0, fce_q};
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q    <= SEG_RESET;
      tshift_q <= TSHIFT_RESET;
      tfe_q    <= 1'b1;
      fce_q    <= 1'b1;
    end else if (cfg_wr) begin
      unique case (reg_idx_e'(paddr[3:2]))
        REG_SEGMENT:  seg_q    <= pwdata[15:0];
        REG_TSHIFT:   tshift_q <= pwdata[5:0];
        REG_FRIENDLY: tfe_q    <= pwdata[0];
        REG_FASTCONV: fce_q    <= pwdata[0];
        default:      seg_q    <= seg_q;
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // event sequencer
  always_comb begin
    logic [TIME_W-1:0] in_now, in_ts, rtt_new;
    logic [63:0]       win64, cand64, tmag, scaled_r, hundred, tgt;
    logic [K_W-1:0]    cand;
    logic [TIME_W:0]   tsum;
    logic [6:0]        shl;
    logic [5:0]        shr;
    logic [WIN_W:0]    wsum;
    logic [WIN_W-1:0]  win_m1;
    logic [BYTE_W-1:0] lim;
    logic [BYTE_W:0]   need;
    logic [64:0]       rsum;

    state_d     = state_q;
    window_d    = window_q;
    thr_d       = thr_q;
    lmw_d       = lmw_q;
    reno_d      = reno_q;
    origin_d    = origin_q;
    koff_d      = koff_q;
    epoch_d     = epoch_q;
    rtt_d       = rtt_q;
    ts_d        = ts_q;
    acks_d      = acks_q;
    incr_d      = incr_q;
    delta_d     = delta_q;
    flight_d    = flight_q;
    started_d   = started_q;
    issued_d    = issued_q;
    out_valid_d = out_valid_q;
    neg_d       = neg_q;
    tmp_d       = tmp_q;
    v_d         = v_q;
    dmag_d      = dmag_q;
    bit_d       = bit_q;
    n_d         = n_q;
    out_data_d  = out_data_q;
    md_req      = '0;

    in_now  = s_axis_tdata[55:0];
    in_ts   = s_axis_tdata[111:56];
    rtt_new = (in_now >= in_ts) ? (in_now - in_ts) : '0;
    win64   = 64'(window_q);
    cand    = koff_q | (K_W'(1) << bit_q);
    cand64  = 64'(cand);
    tsum    = {1'b0, ts_q} + {1'b0, rtt_q};
    // picoseconds to curve units
    shr     = 6'(tshift_q - 6'(FRAC_BITS));
    shl     = 7'(FRAC_BITS) - {1'b0, tshift_q};
    if (tshift_q >= 6'(FRAC_BITS)) begin
      tmag = tmp_q >> shr;
    end else if (|(tmp_q >> (7'd64 - shl))) begin
      tmag = '1;
    end else begin
      tmag = tmp_q << shl;
    end
    scaled_r = '0;
    hundred  = 64'({7'd0, window_q[WIN_W-1:FRAC_BITS]} << 6)
             + 64'({7'd0, window_q[WIN_W-1:FRAC_BITS]} << 5)
             + 64'({7'd0, window_q[WIN_W-1:FRAC_BITS]} << 2);
    tgt      = '0;
    wsum     = '0;
    rsum     = '0;
    win_m1   = window_q - WIN_W'(1);
    lim      = win_m1[WIN_W-1:FRAC_BITS];
    need     = {1'b0, flight_q} + (BYTE_W+1)'(seg_q);

    // result beat handed over
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          ts_d = in_ts;
          n_d  = '0;
          unique case (s_axis_tuser)
            OP_START: begin
              lmw_d     = '0;
              reno_d    = '0;
              acks_d    = '0;
              origin_d  = '0;
              epoch_d   = '0;
              rtt_d     = '0;
              koff_d    = '0;
              started_d = 1'b1;
              state_d   = ST_REL;
            end
            OP_ACK, OP_NACK: begin
              if (!started_q) begin
                state_d = ST_OUT;
              end else begin
                flight_d = (flight_q > BYTE_W'(seg_q)) ? flight_q - BYTE_W'(seg_q) : '0;
                if (s_axis_tuser == OP_NACK) begin
                  epoch_d = '0;
                  state_d = ST_NACK_MAX;
                end else begin
                  if (rtt_q == '0 || rtt_new < rtt_q) begin
                    rtt_d = rtt_new;
                  end
                  state_d = (window_q < thr_q) ? ST_SS_INC : ST_CU_EPOCH;
                end
              end
            end
            default: state_d = ST_OUT;
          endcase
        end
      end

      // loss: remembered maximum, threshold, window times 0.8
      ST_NACK_MAX: begin
        if (!issued_q) begin
          if (window_q < lmw_q && fce_q) begin
            md_req   = '{start: 1'b1, a: win64, b: 64'd9, d: 64'd10};
            issued_d = 1'b1;
          end else begin
            lmw_d   = window_q;
            thr_d   = window_q;
            state_d = ST_NACK_WIN;
          end
        end else if (md_rsp.done) begin
          issued_d = 1'b0;
          lmw_d    = md_rsp.q[WIN_W-1:0];
          thr_d    = md_rsp.q[WIN_W-1:0];
          state_d  = ST_NACK_WIN;
        end
      end
      ST_NACK_WIN: begin
        if (!issued_q) begin
          md_req   = '{start: 1'b1, a: win64, b: 64'd4, d: 64'd5};
          issued_d = 1'b1;
        end else if (md_rsp.done) begin
          issued_d = 1'b0;
          window_d = md_rsp.q[WIN_W-1:0];
          state_d  = ST_REL;
        end
      end

      // slow start growth
      ST_SS_INC: begin
        if (!issued_q) begin
          md_req   = '{start: 1'b1, a: 64'({seg_q, {FRAC_BITS{1'b0}}}),
                       b: 64'(thr_q - window_q), d: 64'(thr_q)};
          issued_d = 1'b1;
        end else if (md_rsp.done) begin
          issued_d = 1'b0;
          tmp_d    = md_rsp.q;
          state_d  = ST_SS_ADD;
        end
      end
      ST_SS_ADD: begin
        if (!issued_q) begin
          md_req   = '{start: 1'b1, a: tmp_q, b: 64'd3, d: 64'd5};
          issued_d = 1'b1;
        end else if (md_rsp.done) begin
          issued_d = 1'b0;
          rsum     = {1'b0, win64} + {1'b0, md_rsp.q};
          window_d = (rsum > 65'(WIN_MAX)) ? WIN_MAX : rsum[WIN_W-1:0];
          state_d  = ST_REL;
        end
      end

      // epoch bookkeeping
      ST_CU_EPOCH: begin
        acks_d = (acks_q == '1) ? acks_q : acks_q + CNT_W'(1);
        if (epoch_q == '0) begin
          epoch_d = ts_q;
          acks_d  = CNT_W'(1);
          if (window_q < lmw_q) begin
            origin_d = lmw_q;
            state_d  = ST_ROOT_V;
          end else begin
            koff_d   = '0;
            origin_d = window_q;
            state_d  = ST_CU_DIFF;
          end
        end else begin
          state_d = ST_CU_DIFF;
        end
      end

      // cube root, one result bit per pass
      ST_ROOT_V: begin
        if (!issued_q) begin
          md_req   = '{start: 1'b1, a: 64'(lmw_q - window_q), b: 64'd5, d: 64'd2};
          issued_d = 1'b1;
        end else if (md_rsp.done) begin
          issued_d = 1'b0;
          v_d      = md_rsp.q;
          koff_d   = '0;
          bit_d    = 6'(K_W - 1);
          state_d  = ST_ROOT_SQ;
        end
      end
      ST_ROOT_SQ: begin
        if (!issued_q) begin
          md_req   = '{start: 1'b1, a: cand64, b: cand64, d: ONE_Q};
          issued_d = 1'b1;
        end else if (md_rsp.done) begin
          issued_d = 1'b0;
          tmp_d    = md_rsp.q;
          state_d  = ST_ROOT_CB;
        end
      end
      ST_ROOT_CB: begin
        if (!issued_q) begin
          md_req   = '{start: 1'b1, a: tmp_q, b: cand64, d: ONE_Q};
          issued_d = 1'b1;
        end else if (md_rsp.done) begin
          issued_d = 1'b0;
          if (md_rsp.q <= v_q) begin
            koff_d = cand;
          end
          if (bit_q == 6'd0) begin
            state_d = ST_CU_DIFF;
          end else begin
            bit_d   = bit_q - 6'd1;
            state_d = ST_ROOT_SQ;
          end
        end
      end

      // distance of curve time from the epoch
      ST_CU_DIFF: begin
        if (tsum >= {1'b0, epoch_q}) begin
          tmp_d = 64'(tsum - {1'b0, epoch_q});
          neg_d = 1'b0;
        end else begin
          tmp_d = 64'({1'b0, epoch_q} - tsum);
          neg_d = 1'b1;
        end
        state_d = ST_CU_SCALE;
      end
      ST_CU_SCALE: begin
        if (neg_q) begin
          dmag_d = sat_add64(tmag, 64'(koff_q));
        end else if (tmag >= 64'(koff_q)) begin
          dmag_d = tmag - 64'(koff_q);
        end else begin
          dmag_d = 64'(koff_q) - tmag;
          neg_d  = 1'b1;
        end
        state_d = ST_CU_SQ;
      end
      ST_CU_SQ: begin
        if (!issued_q) begin
          md_req   = '{start: 1'b1, a: dmag_q, b: dmag_q, d: ONE_Q};
          issued_d = 1'b1;
        end else if (md_rsp.done) begin
          issued_d = 1'b0;
          tmp_d    = md_rsp.q;
          state_d  = ST_CU_CB;
        end
      end
      ST_CU_CB: begin
        if (!issued_q) begin
          md_req   = '{start: 1'b1, a: tmp_q, b: dmag_q, d: ONE_Q};
          issued_d = 1'b1;
        end else if (md_rsp.done) begin
          issued_d = 1'b0;
          tmp_d    = md_rsp.q;
          state_d  = ST_CU_TGT;
        end
      end
      // cubic target, clamped at zero
      ST_CU_TGT: begin
        if (!issued_q) begin
          md_req   = '{start: 1'b1, a: tmp_q, b: 64'd2, d: 64'd5};
          issued_d = 1'b1;
        end else if (md_rsp.done) begin
          issued_d = 1'b0;
          if (neg_q) begin
            tgt = (64'(origin_q) > md_rsp.q) ? 64'(origin_q) - md_rsp.q : '0;
          end else begin
            tgt = sat_add64(64'(origin_q), md_rsp.q);
          end
          tmp_d   = tgt;
          state_d = ST_CU_DELTA;
        end
      end
      // acks needed per segment of growth
      ST_CU_DELTA: begin
        if (!issued_q) begin
          if (tmp_q > win64) begin
            md_req   = '{start: 1'b1, a: win64, b: 64'd1, d: tmp_q - win64};
            issued_d = 1'b1;
          end else begin
            delta_d = sat32(hundred);
            state_d = ST_CU_RENO1;
          end
        end else if (md_rsp.done) begin
          issued_d = 1'b0;
          delta_d  = sat32(md_rsp.q);
          state_d  = ST_CU_RENO1;
        end
      end
      // emulated reno window
      ST_CU_RENO1: begin
        if (!tfe_q) begin
          state_d = ST_CU_INC;
        end else if (!issued_q) begin
          md_req   = '{start: 1'b1, a: 64'({acks_q, {FRAC_BITS{1'b0}}}),
                       b: ONE_Q, d: win64};
          issued_d = 1'b1;
        end else if (md_rsp.done) begin
          issued_d = 1'b0;
          tmp_d    = md_rsp.q;
          state_d  = ST_CU_RENO2;
        end
      end
      ST_CU_RENO2: begin
        if (!issued_q) begin
          md_req   = '{start: 1'b1, a: tmp_q, b: 64'd1, d: 64'd3};
          issued_d = 1'b1;
        end else if (md_rsp.done) begin
          issued_d = 1'b0;
          scaled_r = sat_add64(64'(reno_q), md_rsp.q);
          reno_d   = (scaled_r > 64'(WIN_MAX)) ? WIN_MAX : scaled_r[WIN_W-1:0];
          acks_d   = '0;
          state_d  = ST_CU_CAP;
        end
      end
      ST_CU_CAP: begin
        if (!issued_q) begin
          if (reno_q > window_q) begin
            md_req   = '{start: 1'b1, a: win64, b: 64'd1, d: 64'(reno_q - window_q)};
            issued_d = 1'b1;
          end else begin
            state_d = ST_CU_INC;
          end
        end else if (md_rsp.done) begin
          issued_d = 1'b0;
          if (delta_q > sat32(md_rsp.q)) begin
            delta_d = sat32(md_rsp.q);
          end
          state_d = ST_CU_INC;
        end
      end
      // one segment each time the ack count exceeds delta
      ST_CU_INC: begin
        if (incr_q > delta_q) begin
          wsum     = {1'b0, window_q} + (WIN_W+1)'({seg_q, {FRAC_BITS{1'b0}}});
          window_d = (wsum > {1'b0, WIN_MAX}) ? WIN_MAX : wsum[WIN_W-1:0];
          incr_d   = '0;
        end else begin
          incr_d = (incr_q == '1) ? incr_q : incr_q + CNT_W'(1);
        end
        state_d = ST_REL;
      end

      // release segments while in flight plus one stays below the window
      ST_REL: begin
        if (!issued_q) begin
          if (seg_q == 16'd0 || window_q == '0 || need > {1'b0, lim}) begin
            n_d     = '0;
            state_d = ST_OUT;
          end else begin
            md_req   = '{start: 1'b1, a: 64'(lim - flight_q), b: 64'd1, d: 64'(seg_q)};
            issued_d = 1'b1;
          end
        end else if (md_rsp.done) begin
          issued_d = 1'b0;
          n_d      = (|md_rsp.q[63:REL_W]) ? '1 : md_rsp.q[REL_W-1:0];
          flight_d = lim - md_rsp.rem[BYTE_W-1:0];
          state_d  = ST_OUT;
        end
      end

      // register the result beat
      ST_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_data_d  = {6'd0, rtt_q, flight_q, n_q,
                         thr_q[WIN_W-1:FRAC_BITS], window_q[WIN_W-1:FRAC_BITS]};
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // control and flow state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      window_q    <= WIN_RESET;
      thr_q       <= WIN_MAX;
      lmw_q       <= '0;
      reno_q      <= '0;
      origin_q    <= '0;
      koff_q      <= '0;
      epoch_q     <= '0;
      rtt_q       <= '0;
      acks_q      <= '0;
      incr_q      <= '0;
      flight_q    <= '0;
      started_q   <= 1'b0;
      issued_q    <= 1'b0;
      out_valid_q <= 1'b0;
      bit_q       <= '0;
    end else begin
      state_q     <= state_d;
      window_q    <= window_d;
      thr_q       <= thr_d;
      lmw_q       <= lmw_d;
      reno_q      <= reno_d;
      origin_q    <= origin_d;
      koff_q      <= koff_d;
      epoch_q     <= epoch_d;
      rtt_q       <= rtt_d;
      acks_q      <= acks_d;
      incr_q      <= incr_d;
      flight_q    <= flight_d;
      started_q   <= started_d;
      issued_q    <= issued_d;
      out_valid_q <= out_valid_d;
      bit_q       <= bit_d;
    end
  end

  // working values and result payload
  always_ff @(posedge clk_i) begin
    ts_q       <= ts_d;
    delta_q    <= delta_d;
    neg_q      <= neg_d;
    tmp_q      <= tmp_d;
    v_q        <= v_d;
    dmag_q     <= dmag_d;
    n_q        <= n_d;
    out_data_q <= out_data_d;
  end

`ifndef SYNTH
  // an accepted event keeps the input closed in the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted twice in a row");

  // a result beat appears only from the output state
  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_OUT))
    else $error("result beat without sequencer");

  // the shared unit is never started while busy
  a_md_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    md_req.start |-> !md_rsp.busy)
    else $error("multiply-divide started while busy");

  // once started the flow stays started
  a_started_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    started_q |=> started_q)
    else $error("started flag dropped");
`endif

endmodule

@@ tb/tb_cubic_congestion_window.sv @@
// self-checking testbench for cubic_congestion_window: stream events in, window results out
// depends on ccw_pkg and the block itself; holds its own fixed point window predictor
module tb_cubic_congestion_window;
  import ccw_pkg::*;

  localparam logic [1:0] OP_IGNORED = 2'd3;
  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] BYTES40 = 64'hFF_FFFF_FFFF;
  localparam logic [63:0] MASK56 = (64'd1 << 56) - 1;
  localparam logic [63:0] LIMIT32 = 64'hFFFF_FFFF;

  typedef struct {
    logic [1:0]  op;
    logic [55:0] now_ps;
    logic [55:0] stamp_ps;
  } flow_event_t;

  typedef struct {
    logic [39:0] window_bytes;
    logic [39:0] threshold_bytes;
    logic [9:0]  packets_released;
    logic [39:0] flight_bytes;
    logic [55:0] min_rtt;
  } window_report_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  cubic_congestion_window dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // predictor copy of the registers and flow state
  logic [63:0] seg_cfg, shift_cfg, friendly_cfg, fastconv_cfg;
  logic [63:0] win_q, thresh_q, max_win_q, reno_q, origin_q, k_q, epoch_q;
  logic [63:0] rtt_min_q, ack_run_q, inc_count_q, flight_q;
  logic flow_on;

  flow_event_t pending_events[$];
  window_report_t window_due[$];
  int mismatches = 0;

  // floor(a*b/d), saturating
  function automatic logic [63:0] scaled_quotient(logic [63:0] a, logic [63:0] b,
                                                  logic [63:0] d);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    if (d == 0 || p[127:64] >= d) return ALL_ONES;
    return 64'(p / {64'd0, d});
  endfunction

  function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? ALL_ONES : s[63:0];
  endfunction

  function automatic logic [63:0] clip(logic [63:0] v, logic [63:0] lim);
    return v > lim ? lim : v;
  endfunction

  function automatic logic [63:0] cube_fix(logic [63:0] k);
    return scaled_quotient(scaled_quotient(k, k, ONE_Q), k, ONE_Q);
  endfunction

  function automatic logic [63:0] cube_root_fix(logic [63:0] v);
    logic [63:0] k, c;
    k = 0;
    for (int b = 39; b >= 0; b--) begin
      c = k | (64'd1 << b);
      if (cube_fix(c) <= v) k = c;
    end
    return k;
  endfunction

  // picoseconds to curve units with fraction bits
  function automatic logic [63:0] curve_time(logic [63:0] ps);
    int sh;
    if (shift_cfg >= FRAC_BITS) return ps >> (shift_cfg - FRAC_BITS);
    sh = FRAC_BITS - int'(shift_cfg);
    if ((ps >> (64 - sh)) != 0) return ALL_ONES;
    return ps << sh;
  endfunction

  function automatic void forget_curve();
    max_win_q = 0; reno_q = 0; ack_run_q = 0;
    origin_q = 0; epoch_q = 0; rtt_min_q = 0; k_q = 0;
  endfunction

  // acks needed per segment of growth on the cubic curve
  function automatic logic [63:0] acks_per_segment(logic [63:0] ts);
    logic [63:0] sum, tmag, dmag, c, target, delta, inc, mc;
    logic neg;
    ack_run_q = clip(ack_run_q + 1, LIMIT32);
    if (epoch_q == 0) begin
      epoch_q = ts;
      if (win_q < max_win_q) begin
        k_q = cube_root_fix(scaled_quotient(max_win_q - win_q, 5, 2));
        origin_q = max_win_q;
      end else begin
        k_q = 0;
        origin_q = win_q;
      end
      ack_run_q = 1;
    end
    sum = ts + rtt_min_q;
    if (sum >= epoch_q) begin
      tmag = curve_time(sum - epoch_q);
      neg = 1'b0;
    end else begin
      tmag = curve_time(epoch_q - sum);
      neg = 1'b1;
    end
    if (neg) dmag = add_sat(tmag, k_q);
    else if (tmag >= k_q) dmag = tmag - k_q;
    else begin
      dmag = k_q - tmag;
      neg = 1'b1;
    end
    c = scaled_quotient(cube_fix(dmag), 2, 5);
    if (neg) target = origin_q > c ? origin_q - c : 0;
    else target = add_sat(origin_q, c);
    if (target > win_q) delta = clip(scaled_quotient(win_q, 1, target - win_q), LIMIT32);
    else delta = clip(64'd100 * (win_q >> FRAC_BITS), LIMIT32);
    if (friendly_cfg[0]) begin
      inc = scaled_quotient(scaled_quotient(ack_run_q << FRAC_BITS, ONE_Q, win_q), 1, 3);
      reno_q = clip(add_sat(reno_q, inc), 64'(WIN_MAX));
      ack_run_q = 0;
      if (reno_q > win_q) begin
        mc = clip(scaled_quotient(win_q, 1, reno_q - win_q), LIMIT32);
        if (delta > mc) delta = mc;
      end
    end
    return delta;
  endfunction

  function automatic logic [63:0] release_segments();
    logic [63:0] lim, n;
    if (seg_cfg == 0 || win_q == 0) return 0;
    lim = (win_q - 1) >> FRAC_BITS;
    if (flight_q + seg_cfg > lim) return 0;
    n = (lim - flight_q) / seg_cfg;
    flight_q += n * seg_cfg;
    return n;
  endfunction

  // work out the report the block owes for one event
  function automatic window_report_t advance_window(flow_event_t ev);
    window_report_t r;
    logic [63:0] n, rtt, inc, delta, now, ts;
    n = 0;
    now = 64'(ev.now_ps);
    ts = 64'(ev.stamp_ps);
    if (ev.op == OP_START) begin
      forget_curve();
      flow_on = 1'b1;
      n = release_segments();
    end else if (ev.op != OP_IGNORED && flow_on) begin
      flight_q = flight_q > seg_cfg ? flight_q - seg_cfg : 0;
      if (ev.op == OP_NACK) begin
        epoch_q = 0;
        if (win_q < max_win_q && fastconv_cfg[0]) max_win_q = scaled_quotient(win_q, 9, 10);
        else max_win_q = win_q;
        thresh_q = max_win_q;
        win_q = scaled_quotient(win_q, 4, 5);
      end else begin
        rtt = now >= ts ? now - ts : 0;
        if (rtt_min_q == 0 || rtt < rtt_min_q) rtt_min_q = rtt;
        if (win_q < thresh_q) begin
          inc = scaled_quotient(seg_cfg << FRAC_BITS, thresh_q - win_q, thresh_q);
          win_q = clip(add_sat(win_q, scaled_quotient(inc, 3, 5)), 64'(WIN_MAX));
        end else begin
          delta = acks_per_segment(ts);
          if (inc_count_q > delta) begin
            win_q = clip(add_sat(win_q, seg_cfg << FRAC_BITS), 64'(WIN_MAX));
            inc_count_q = 0;
          end else begin
            inc_count_q = clip(inc_count_q + 1, LIMIT32);
          end
        end
      end
      n = release_segments();
    end
    r.window_bytes = 40'((win_q >> FRAC_BITS) & BYTES40);
    r.threshold_bytes = 40'((thresh_q >> FRAC_BITS) & BYTES40);
    r.packets_released = n > 1023 ? 10'd1023 : 10'(n);
    r.flight_bytes = 40'(flight_q & BYTES40);
    r.min_rtt = 56'(rtt_min_q & MASK56);
    return r;
  endfunction

  // gap lengths: mostly short, a few long, with quiet stretches
  function automatic int pick_gap(logic quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 80);
  endfunction

  // input driver
  flow_event_t cur_event;
  int send_gap = 0;
  logic send_quiet = 1'b0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        window_due.push_back(advance_window(cur_event));
        if ($urandom_range(0, 59) == 0) send_quiet = ~send_quiet;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_events.size() > 0) begin
          cur_event = pending_events.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {cur_event.stamp_ps, cur_event.now_ps};
          s_axis_tuser <= cur_event.op;
          send_gap = pick_gap(send_quiet);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor and ready stalls
  int stall_left = 0;
  logic recv_quiet = 1'b0;
  always @(posedge clk_i) begin
    window_report_t got, want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.window_bytes = m_axis_tdata[39:0];
        got.threshold_bytes = m_axis_tdata[79:40];
        got.packets_released = m_axis_tdata[89:80];
        got.flight_bytes = m_axis_tdata[129:90];
        got.min_rtt = m_axis_tdata[185:130];
        if (window_due.size() == 0) begin
          $error("result beat with no event outstanding");
          mismatches++;
        end else begin
          want = window_due.pop_front();
          if (got.window_bytes !== want.window_bytes) begin
            $error("window_bytes expected %0d got %0d", want.window_bytes, got.window_bytes);
            mismatches++;
          end
          if (got.threshold_bytes !== want.threshold_bytes) begin
            $error("threshold_bytes expected %0d got %0d", want.threshold_bytes,
                   got.threshold_bytes);
            mismatches++;
          end
          if (got.packets_released !== want.packets_released) begin
            $error("packets_released expected %0d got %0d", want.packets_released,
                   got.packets_released);
            mismatches++;
          end
          if (got.flight_bytes !== want.flight_bytes) begin
            $error("flight_bytes expected %0d got %0d", want.flight_bytes, got.flight_bytes);
            mismatches++;
          end
          if (got.min_rtt !== want.min_rtt) begin
            $error("min_rtt expected %0d got %0d", want.min_rtt, got.min_rtt);
            mismatches++;
          end
        end
        if ($urandom_range(0, 49) == 0) recv_quiet = ~recv_quiet;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        stall_left = pick_gap(recv_quiet);
        m_axis_tready <= (stall_left == 0);
      end
    end
  end

  // register write: setup then access
  task automatic write_reg(reg_idx_e idx, logic [31:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_SEGMENT:  seg_cfg = 64'(value[15:0]);
      REG_TSHIFT:   shift_cfg = 64'(value[5:0]);
      REG_FRIENDLY: friendly_cfg = 64'(value[0]);
      REG_FASTCONV: fastconv_cfg = 64'(value[0]);
      default: ;
    endcase
  endtask

  task automatic set_config(logic [15:0] seg, logic [5:0] sh, logic fr, logic fc);
    write_reg(REG_SEGMENT, 32'(seg));
    write_reg(REG_TSHIFT, 32'(sh));
    write_reg(REG_FRIENDLY, 32'(fr));
    write_reg(REG_FASTCONV, 32'(fc));
  endtask

  task automatic queue_event(logic [1:0] op, logic [55:0] now, logic [55:0] ts);
    flow_event_t ev;
    ev.op = op;
    ev.now_ps = now;
    ev.stamp_ps = ts;
    pending_events.push_back(ev);
  endtask

  // wait until every report is in, then let the block settle
  task automatic drain();
    while (pending_events.size() != 0 || s_axis_tvalid || window_due.size() != 0)
      @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  // one flow: a start, then timed acks with some losses and a little noise
  task automatic run_flow(int count);
    logic [63:0] now, step, rtt;
    int r;
    now = 64'($urandom_range(1, 1000)) << shift_cfg[5:0];
    queue_event(OP_START, 56'(now), 56'($urandom));
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      step = ((64'($urandom_range(1, 4096)) << shift_cfg[5:0]) >> 10) + 1;
      now = now + step;
      if (now > (64'd1 << 55)) now = 64'($urandom_range(1, 1 << 20));
      rtt = (64'($urandom_range(1, 4096)) << shift_cfg[5:0]) >> 12;
      if (rtt > now) rtt = now;
      if (r < 78) queue_event(OP_ACK, 56'(now), 56'(now - rtt));
      else if (r < 88) queue_event(OP_NACK, 56'(now), 56'(now - rtt));
      else if (r < 90) queue_event(OP_START, 56'(now), 56'(now));
      else if (r < 92) queue_event(OP_IGNORED, 56'({$urandom, $urandom}),
                                   56'({$urandom, $urandom}));
      else if (r < 94) queue_event(OP_ACK, 56'(now), 56'(0));
      else if (r < 96) queue_event(OP_ACK, 56'(now), 56'(now + rtt + 1));
      else queue_event(2'($urandom_range(0, 2)), 56'({$urandom, $urandom}),
                       56'({$urandom, $urandom}));
    end
    drain();
  endtask

  initial begin
    seg_cfg = 1500; shift_cfg = 30; friendly_cfg = 1; fastconv_cfg = 1;
    win_q = 64'(WIN_RESET); thresh_q = 64'(WIN_MAX);
    forget_curve();
    inc_count_q = 0; flight_q = 0; flow_on = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: events before start, ignored kind, field extremes, odd stamps
    queue_event(OP_ACK, 56'd1000, 56'd10);
    queue_event(OP_NACK, 56'd2000, 56'd10);
    queue_event(OP_IGNORED, '1, '1);
    queue_event(OP_START, '0, '0);
    queue_event(OP_ACK, 56'd5000, 56'd4000);
    queue_event(OP_ACK, 56'd6000, 56'd9000);
    queue_event(OP_ACK, 56'd7000, 56'd6500);
    queue_event(OP_ACK, 56'd8000, 56'd0);
    queue_event(OP_NACK, 56'd9000, 56'd8500);
    queue_event(OP_ACK, 56'd10000, 56'd9900);
    queue_event(OP_ACK, 56'd12000, 56'd11800);
    queue_event(OP_NACK, 56'd13000, 56'd12900);
    queue_event(OP_NACK, 56'd14000, 56'd13900);
    queue_event(OP_ACK, '1, '1);
    queue_event(OP_ACK, '1, '0);
    queue_event(OP_START, '1, '1);
    queue_event(OP_IGNORED, '0, '0);
    queue_event(OP_ACK, 56'd20000, 56'd19000);
    drain();

    // segment size extremes, the smallest time shift, both values of each flag, then random settings
    set_config(16'd1, 6'd0, 1'b0, 1'b0);
    run_flow(60);
    set_config(16'd65535, 6'd48, 1'b1, 1'b1);
    run_flow(40);
    set_config(16'd1500, 6'd20, 1'b1, 1'b0);
    run_flow(80);
    set_config(16'd9000, 6'd10, 1'b0, 1'b1);
    run_flow(60);
    for (int p = 0; p < 4; p++) begin
      set_config(16'($urandom_range(1, 65535)), 6'($urandom_range(0, 48)),
                 1'($urandom), 1'($urandom));
      run_flow(60);
    end
    set_config(16'($urandom_range(1, 3000)), 6'($urandom_range(12, 36)), 1'b1, 1'b1);
    run_flow(40);

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // watchdog
  initial begin
    #60000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
